// ===== hdl/dscr_pkg.sv =====
package dscr_pkg;

    // Default number of entries in each receive and transmit FIFO.
    localparam int FIFO_DEPTH_DEF = 16;

    // Depth of the queue between front and back, and of the result queue.
    localparam int CQ_DEPTH = 4;
    localparam int CQ_AW    = $clog2(CQ_DEPTH);
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);

    // Operation codes of an input item.
    localparam logic [1:0] OP_READ     = 2'd0;
    localparam logic [1:0] OP_WRITE    = 2'd1;
    localparam logic [1:0] OP_HOST_POP = 2'd2;

    // Bus address map.
    localparam logic [3:0] ADDR_CMD_B  = 4'h8;
    localparam logic [3:0] ADDR_CMD_A  = 4'h9;
    localparam logic [3:0] ADDR_DATA_B = 4'hA;
    localparam logic [3:0] ADDR_DATA_A = 4'hB;

    // Register pointer values with a fixed meaning on a command read.
    localparam logic [3:0] PTR_STATUS = 4'd0;
    localparam logic [3:0] PTR_RR1    = 4'd1;

    // Write register 14 bit 4 enables local loopback.
    localparam logic [3:0] LOOPBACK_REG = 4'd14;
    localparam int         LOOPBACK_BIT = 4;

    localparam logic [7:0] STATUS_BASE    = 8'h04;
    localparam logic [7:0] STATUS_RXAVAIL = 8'h01;
    localparam logic [7:0] RR1_VALUE      = 8'h01;

    typedef struct packed {
        logic [1:0] op;
        logic [3:0] reg_addr;
        logic [7:0] write_data;
        logic       host_channel;
    } t_in;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       dropped;
    } t_out;

    // Classified operation handed from the front to the back.
    typedef enum logic [2:0] {
        K_NONE,
        K_CMD_RD,
        K_CMD_WR,
        K_DAT_RD,
        K_DAT_WR,
        K_HOST_POP
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic       ch;
        logic [7:0] data;
    } t_cmd;

endpackage

// ===== hdl/dual_serial_controller_regs.sv =====
// Register interface of a simplified two-channel serial controller.
// Input channel: an item (bus read, bus write or host pop of a transmit byte)
// is taken on a rising edge with push high and full low. Result channel: while
// empty is low the oldest result sits on o_result, and it is removed on a
// rising edge with pop high. Every item, including one to an unmapped address,
// gives exactly one result, in the order the items were accepted.
// An item passes from the front queue to the execute stage, then through the
// registered FIFO read, and its result is written into the result queue.
// Throughput: one item per cycle, sustained while the receiver keeps popping;
// each item is a single register or FIFO operation, done by the execute stage
// against the channel state and the FIFO memories.
// A four-entry queue separates front and back, and a four-entry result queue
// follows the execute stage. When the receiver stalls, the result queue fills,
// the execute stage holds, then the front queue fills and full is raised;
// nothing is lost or repeated.
// Reset (synchronous, active low) clears the register pointers, the write
// registers, all FIFO counts and heads, and both queues. FIFO storage itself
// is not cleared; only entries that have been written are ever read.
module dual_serial_controller_regs #(
    parameter int FIFO_DEPTH = dscr_pkg::FIFO_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  dscr_pkg::t_in  i_item,
    output logic           empty,
    input  logic           pop,
    output dscr_pkg::t_out o_result
);
    import dscr_pkg::*;

    // Classified operations travelling from the front to the execute stage.
    logic cmd_valid;
    logic cmd_take;
    t_cmd cmd;

    // The front decodes each item and queues it, so that acceptance never
    // waits on the execute stage unless its queue is full.
    dscr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    // The back holds the channel state and FIFOs and produces the results.
    dscr_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

endmodule

// ===== hdl/dscr_front.sv =====
module dscr_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  dscr_pkg::t_in  i_item,
    output logic           o_cmd_valid,
    output dscr_pkg::t_cmd o_cmd,
    input  logic           i_cmd_take
);
    import dscr_pkg::*;

    t_cmd              r_q [CQ_DEPTH];
    logic [CQ_AW-1:0]  r_wr;
    logic [CQ_AW-1:0]  r_rd;
    logic [CQ_AW:0]    r_cnt;
    t_cmd              n_cmd;
    logic              accept;
    logic              take;

    // Decode the bus address and operation into one kind of work.
    always_comb begin
        n_cmd.kind = K_NONE;
        n_cmd.ch   = i_item.reg_addr[0];
        n_cmd.data = i_item.write_data;
        case (i_item.op)
            OP_READ: begin
                case (i_item.reg_addr)
                    ADDR_CMD_B, ADDR_CMD_A:   n_cmd.kind = K_CMD_RD;
                    ADDR_DATA_B, ADDR_DATA_A: n_cmd.kind = K_DAT_RD;
                    default:                  n_cmd.kind = K_NONE;
                endcase
            end
            OP_WRITE: begin
                case (i_item.reg_addr)
                    ADDR_CMD_B, ADDR_CMD_A:   n_cmd.kind = K_CMD_WR;
                    ADDR_DATA_B, ADDR_DATA_A: n_cmd.kind = K_DAT_WR;
                    default:                  n_cmd.kind = K_NONE;
                endcase
            end
            OP_HOST_POP: begin
                n_cmd.kind = K_HOST_POP;
                n_cmd.ch   = i_item.host_channel;
            end
            default: n_cmd.kind = K_NONE;
        endcase
    end

    assign full        = (r_cnt == (CQ_AW+1)'(CQ_DEPTH));
    assign accept      = push && !full;
    assign o_cmd_valid = (r_cnt != '0);
    assign take        = i_cmd_take && o_cmd_valid;
    assign o_cmd       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wr] <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (accept) begin
                r_wr <= r_wr + 1'b1;
            end
            if (take) begin
                r_rd <= r_rd + 1'b1;
            end
            if (accept && !take) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (take && !accept) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/dscr_back.sv =====
module dscr_back #(
    parameter int FIFO_DEPTH = dscr_pkg::FIFO_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  dscr_pkg::t_cmd i_cmd,
    output logic           o_cmd_take,
    output logic           empty,
    input  logic           pop,
    output dscr_pkg::t_out o_result
);
    import dscr_pkg::*;

    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int IW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int SW = CW + 1;

    typedef enum logic [1:0] {
        SRC_CONST,
        SRC_RX,
        SRC_TX
    } t_src;

    // Channel state.
    logic [3:0]    r_ptr   [2];
    logic [7:0]    r_wregs [2][16];
    logic          r_loop  [2];
    logic [CW-1:0] r_rx_cnt  [2];
    logic [CW-1:0] r_tx_cnt  [2];
    logic [IW-1:0] r_rx_head [2];
    logic [IW-1:0] r_tx_head [2];

    // FIFO storage.
    logic [7:0] rx_mem [2][FIFO_DEPTH];
    logic [7:0] tx_mem [2][FIFO_DEPTH];
    logic [7:0] r_rx_q;
    logic [7:0] r_tx_q;

    // Second stage.
    logic       r_s2_valid;
    t_src       r_s2_src;
    logic [7:0] r_s2_const;
    logic       r_s2_txv;
    logic       r_s2_drop;

    // Result queue.
    t_out             r_oq [OQ_DEPTH];
    logic [OQ_AW-1:0] r_oq_wr;
    logic [OQ_AW-1:0] r_oq_rd;
    logic [OQ_AW:0]   r_oq_cnt;

    logic          issue;
    logic          ch;
    logic [3:0]    ptr;
    logic [CW-1:0] rx_cnt;
    logic [CW-1:0] tx_cnt;
    logic [IW-1:0] rx_head;
    logic [IW-1:0] tx_head;
    logic [SW-1:0] rx_sum;
    logic [SW-1:0] tx_sum;
    logic [IW-1:0] rx_tail;
    logic [IW-1:0] tx_tail;
    logic          rx_has;
    logic          tx_has;
    logic          rx_room;
    logic          tx_room;

    logic       rx_we;
    logic       tx_we;
    logic       rx_re;
    logic       tx_re;
    logic       ptr_we;
    logic [3:0] n_ptr;
    logic       wreg_we;
    t_src       n_src;
    logic [7:0] n_const;
    logic       n_txv;
    logic       n_drop;
    t_out       s2_res;
    logic       oq_pop;

    assign issue      = i_cmd_valid &&
                        ((r_oq_cnt + (OQ_AW+1)'(r_s2_valid)) < (OQ_AW+1)'(OQ_DEPTH));
    assign o_cmd_take = issue;

    assign ch      = i_cmd.ch;
    assign ptr     = r_ptr[ch];
    assign rx_cnt  = r_rx_cnt[ch];
    assign tx_cnt  = r_tx_cnt[ch];
    assign rx_head = r_rx_head[ch];
    assign tx_head = r_tx_head[ch];
    assign rx_has  = (rx_cnt != '0);
    assign tx_has  = (tx_cnt != '0);
    assign rx_room = (rx_cnt < CW'(FIFO_DEPTH));
    assign tx_room = (tx_cnt < CW'(FIFO_DEPTH));

    // Tail is head plus count, folded back once into the ring.
    assign rx_sum  = SW'(rx_head) + SW'(rx_cnt);
    assign tx_sum  = SW'(tx_head) + SW'(tx_cnt);
    assign rx_tail = (rx_sum >= SW'(FIFO_DEPTH)) ?
                     IW'(rx_sum - SW'(FIFO_DEPTH)) : IW'(rx_sum);
    assign tx_tail = (tx_sum >= SW'(FIFO_DEPTH)) ?
                     IW'(tx_sum - SW'(FIFO_DEPTH)) : IW'(tx_sum);

    function automatic logic [IW-1:0] head_inc(input logic [IW-1:0] h);
        logic [IW-1:0] res;
        if (h == IW'(FIFO_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = h + 1'b1;
        end
        return res;
    endfunction

    always_comb begin
        rx_we   = 1'b0;
        tx_we   = 1'b0;
        rx_re   = 1'b0;
        tx_re   = 1'b0;
        ptr_we  = 1'b0;
        n_ptr   = '0;
        wreg_we = 1'b0;
        n_src   = SRC_CONST;
        n_const = '0;
        n_txv   = 1'b0;
        n_drop  = 1'b0;
        case (i_cmd.kind)
            K_CMD_RD: begin
                ptr_we = 1'b1;
                if (ptr == PTR_STATUS) begin
                    n_const = STATUS_BASE | (rx_has ? STATUS_RXAVAIL : 8'h00);
                end else if (ptr == PTR_RR1) begin
                    n_const = RR1_VALUE;
                end else begin
                    n_const = r_wregs[ch][ptr];
                end
            end
            K_CMD_WR: begin
                ptr_we = 1'b1;
                if (ptr == PTR_STATUS) begin
                    n_ptr = i_cmd.data[3:0];
                end else begin
                    wreg_we = 1'b1;
                end
            end
            K_DAT_RD: begin
                if (rx_has) begin
                    rx_re = 1'b1;
                    n_src = SRC_RX;
                end
            end
            K_DAT_WR: begin
                tx_we  = tx_room;
                n_drop = !tx_room;
                if (r_loop[ch]) begin
                    rx_we = rx_room;
                    if (!rx_room) begin
                        n_drop = 1'b1;
                    end
                end
            end
            K_HOST_POP: begin
                if (tx_has) begin
                    tx_re = 1'b1;
                    n_txv = 1'b1;
                    n_src = SRC_TX;
                end
            end
            default: n_src = SRC_CONST;
        endcase
    end

    // FIFO storage: each side does one write or one registered read per cycle, only when an item issues.
    always_ff @(posedge i_clk) begin
        if (issue && rx_we) begin
            rx_mem[ch][rx_tail] <= i_cmd.data;
        end
        if (issue && rx_re) begin
            r_rx_q <= rx_mem[ch][rx_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue && tx_we) begin
            tx_mem[ch][tx_tail] <= i_cmd.data;
        end
        if (issue && tx_re) begin
            r_tx_q <= tx_mem[ch][tx_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 2; c++) begin
                r_ptr[c]     <= '0;
                r_loop[c]    <= 1'b0;
                r_rx_cnt[c]  <= '0;
                r_tx_cnt[c]  <= '0;
                r_rx_head[c] <= '0;
                r_tx_head[c] <= '0;
                for (int r = 0; r < 16; r++) begin
                    r_wregs[c][r] <= '0;
                end
            end
        end else if (issue) begin
            if (ptr_we) begin
                r_ptr[ch] <= n_ptr;
            end
            if (wreg_we) begin
                r_wregs[ch][ptr] <= i_cmd.data;
                if (ptr == LOOPBACK_REG) begin
                    r_loop[ch] <= i_cmd.data[LOOPBACK_BIT];
                end
            end
            if (rx_we) begin
                r_rx_cnt[ch] <= rx_cnt + 1'b1;
            end else if (rx_re) begin
                r_rx_cnt[ch]  <= rx_cnt - 1'b1;
                r_rx_head[ch] <= head_inc(rx_head);
            end
            if (tx_we) begin
                r_tx_cnt[ch] <= tx_cnt + 1'b1;
            end else if (tx_re) begin
                r_tx_cnt[ch]  <= tx_cnt - 1'b1;
                r_tx_head[ch] <= head_inc(tx_head);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s2_src   <= n_src;
            r_s2_const <= n_const;
            r_s2_txv   <= n_txv;
            r_s2_drop  <= n_drop;
        end
    end

    // Merge the FIFO read data into the result.
    always_comb begin
        s2_res.read_data = (r_s2_src == SRC_RX) ? r_rx_q : r_s2_const;
        s2_res.tx_valid  = r_s2_txv;
        s2_res.tx_byte   = (r_s2_src == SRC_TX) ? r_tx_q : 8'h00;
        s2_res.dropped   = r_s2_drop;
    end

    assign empty    = (r_oq_cnt == '0);
    assign oq_pop   = pop && !empty;
    assign o_result = r_oq[r_oq_rd];

    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_oq[r_oq_wr] <= s2_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wr  <= '0;
            r_oq_rd  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (r_s2_valid) begin
                r_oq_wr <= r_oq_wr + 1'b1;
            end
            if (oq_pop) begin
                r_oq_rd <= r_oq_rd + 1'b1;
            end
            if (r_s2_valid && !oq_pop) begin
                r_oq_cnt <= r_oq_cnt + 1'b1;
            end else if (oq_pop && !r_s2_valid) begin
                r_oq_cnt <= r_oq_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== dv/tb_dual_serial_controller_regs.sv =====
// Checks the two-channel serial controller register interface against a predictor kept here.
// Every accepted item is run through the predictor. Each result taken from the block is
// compared field by field with the oldest predicted result still waiting.
module tb_dual_serial_controller_regs;
    import dscr_pkg::*;

    localparam int DEPTH           = FIFO_DEPTH_DEF;
    // A stall at 81 per cent practically never lasts this long, so a quiet stretch
    // of this length means that the block has hung.
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int ITEMS_PER_PHASE = 385;
    // The fourth operation code has no function. The block must answer it with an all-zero result.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // Predictor FIFO slots: receive FIFOs sit at the channel number and transmit FIFOs above them.
    localparam int TX_BASE = 2;

    // Holds its own copy of the channel state and predicts the result of each item.
    class ctrl_scoreboard;
        logic [7:0] wreg [2][16];
        logic [3:0] ptr [2];
        logic [7:0] fifo_mem [4][DEPTH];
        int         fifo_head [4];
        int         fifo_cnt [4];
        t_out       expected_results [$];
        int         errors;
        int         checked;
        int         drops;
        int         loopbacks;
        int         tx_handed;

        function new();
            for (int c = 0; c < 2; c++) begin
                ptr[c] = PTR_STATUS;
                for (int r = 0; r < 16; r++) wreg[c][r] = '0;
            end
            for (int f = 0; f < 4; f++) begin
                fifo_head[f] = 0;
                fifo_cnt[f]  = 0;
            end
            errors = 0;
            checked = 0;
            drops = 0;
            loopbacks = 0;
            tx_handed = 0;
        endfunction

        function bit fifo_push(int f, logic [7:0] v);
            if (fifo_cnt[f] >= DEPTH) return 1'b0;
            fifo_mem[f][(fifo_head[f] + fifo_cnt[f]) % DEPTH] = v;
            fifo_cnt[f]++;
            return 1'b1;
        endfunction

        function bit fifo_pop(int f, output logic [7:0] v);
            v = '0;
            if (fifo_cnt[f] == 0) return 1'b0;
            v = fifo_mem[f][fifo_head[f]];
            fifo_head[f] = (fifo_head[f] + 1) % DEPTH;
            fifo_cnt[f]--;
            return 1'b1;
        endfunction

        function logic [7:0] command_read(bit ch);
            logic [3:0] p;
            p = ptr[ch];
            ptr[ch] = PTR_STATUS;
            if (p == PTR_STATUS)
                return (fifo_cnt[ch] != 0) ? (STATUS_BASE | STATUS_RXAVAIL) : STATUS_BASE;
            if (p == PTR_RR1) return RR1_VALUE;
            return wreg[ch][p];
        endfunction

        function void command_write(bit ch, logic [7:0] v);
            if (ptr[ch] == PTR_STATUS) begin
                ptr[ch] = v[3:0];
            end else begin
                wreg[ch][ptr[ch]] = v;
                ptr[ch] = PTR_STATUS;
            end
        endfunction

        // The transmit FIFO takes the byte when it has room. The receive FIFO also takes it under loopback.
        // A full FIFO on either side marks the item as dropped.
        function bit data_write(bit ch, logic [7:0] v);
            bit lost;
            lost = !fifo_push(TX_BASE + ch, v);
            if (wreg[ch][LOOPBACK_REG][LOOPBACK_BIT]) begin
                loopbacks++;
                if (!fifo_push(ch, v)) lost = 1'b1;
            end
            if (lost) drops++;
            return lost;
        endfunction

        function void note_item(t_in it);
            t_out       r;
            logic [7:0] v;
            bit         ch;
            bit         is_cmd;
            bit         is_data;
            r = '0;
            ch = (it.reg_addr == ADDR_CMD_A) || (it.reg_addr == ADDR_DATA_A);
            is_cmd = (it.reg_addr == ADDR_CMD_A) || (it.reg_addr == ADDR_CMD_B);
            is_data = (it.reg_addr == ADDR_DATA_A) || (it.reg_addr == ADDR_DATA_B);
            case (it.op)
                OP_READ: begin
                    if (is_cmd) begin
                        r.read_data = command_read(ch);
                    end else if (is_data) begin
                        if (fifo_pop(ch, v)) r.read_data = v;
                    end
                end
                OP_WRITE: begin
                    if (is_cmd) command_write(ch, it.write_data);
                    else if (is_data) r.dropped = data_write(ch, it.write_data);
                end
                OP_HOST_POP: begin
                    if (fifo_pop(TX_BASE + it.host_channel, v)) begin
                        r.tx_valid = 1'b1;
                        r.tx_byte = v;
                        tx_handed++;
                    end
                end
                default: ;
            endcase
            expected_results.insert(expected_results.size(), r);
        endfunction

        function void report(string field, logic [7:0] exp_v, logic [7:0] got_v);
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, field, exp_v, got_v);
        endfunction

        function void check_result(t_out got);
            t_out exp_r;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: result 0x%0h arrived, expected none", $time, got);
                return;
            end
            exp_r = expected_results[0];
            expected_results.delete(0);
            checked++;
            if (got.read_data !== exp_r.read_data)
                report("read_data", exp_r.read_data, got.read_data);
            if (got.tx_valid !== exp_r.tx_valid)
                report("tx_valid", 8'(exp_r.tx_valid), 8'(got.tx_valid));
            if (got.tx_byte !== exp_r.tx_byte)
                report("tx_byte", exp_r.tx_byte, got.tx_byte);
            if (got.dropped !== exp_r.dropped)
                report("dropped", 8'(exp_r.dropped), 8'(got.dropped));
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic push;
    logic full;
    t_in  i_item;
    logic empty;
    logic pop;
    t_out o_result;

    ctrl_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int counted_items;
    int quiet_cycles;

    always #6 i_clk = ~i_clk;

    dual_serial_controller_regs #(
        .FIFO_DEPTH(DEPTH)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    // Result side. Outputs are sampled straight after the edge, so the values seen are
    // the ones that the block presented at that edge. The pop for the next edge is then
    // decided once per cycle, which gives one nonblocking assignment per time step.
    always @(posedge i_clk) begin
        if (pop && !empty) sb.check_result(o_result);
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog. It counts consecutive cycles in which neither side moves an item.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_LIMIT, sb.expected_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Presents one item and holds it until the block takes it. push stays high into the
    // next item unless an idle gap is drawn. When a gap is drawn, push is lowered and
    // stays low over clock edges until a fresh draw ends the gap.
    task automatic send_item(t_in it);
        push <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_item(it);
        // Items that the block merely ignores do not count towards the phase quota.
        if (it.op == OP_HOST_POP ||
            ((it.op == OP_READ || it.op == OP_WRITE) && it.reg_addr >= ADDR_CMD_B &&
             it.reg_addr <= ADDR_DATA_A))
            counted_items++;
        if ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic bus_write(logic [3:0] addr, logic [7:0] v);
        send_item('{op: OP_WRITE, reg_addr: addr, write_data: v,
                    host_channel: 1'($urandom_range(1))});
    endtask

    task automatic bus_read(logic [3:0] addr);
        send_item('{op: OP_READ, reg_addr: addr, write_data: 8'($urandom_range(255)),
                    host_channel: 1'($urandom_range(1))});
    endtask

    task automatic host_pop(logic ch);
        send_item('{op: OP_HOST_POP, reg_addr: 4'($urandom_range(15)),
                    write_data: 8'($urandom_range(255)), host_channel: ch});
    endtask

    // Short directed opening. It reads the status bytes after reset, pops both FIFO kinds
    // while they are empty, sends unmapped and unused items, reads register 1, and runs
    // loopback on channel B. It finishes with a register round trip and a transmit byte
    // on channel A.
    task automatic run_directed();
        bus_read(ADDR_CMD_B);
        bus_read(ADDR_CMD_A);
        bus_read(ADDR_DATA_B);
        host_pop(1'b1);
        bus_read(4'h0);
        bus_write(4'hF, 8'hFF);
        send_item('{op: OP_UNUSED, reg_addr: 4'hF, write_data: 8'hFF, host_channel: 1'b1});
        // The high nibble of a pointer write must be ignored.
        bus_write(ADDR_CMD_A, {4'hF, PTR_RR1});
        bus_read(ADDR_CMD_A);
        bus_write(ADDR_CMD_B, {4'h0, LOOPBACK_REG});
        bus_write(ADDR_CMD_B, 8'(1 << LOOPBACK_BIT));
        bus_write(ADDR_CMD_B, {4'h0, LOOPBACK_REG});
        bus_read(ADDR_CMD_B);
        bus_write(ADDR_DATA_B, 8'h00);
        bus_write(ADDR_DATA_B, 8'hFF);
        // The status byte now shows that receive data is waiting.
        bus_read(ADDR_CMD_B);
        bus_read(ADDR_DATA_B);
        bus_read(ADDR_DATA_B);
        host_pop(1'b0);
        host_pop(1'b0);
        bus_write(ADDR_CMD_A, 8'h0F);
        bus_write(ADDR_CMD_A, 8'hAA);
        bus_write(ADDR_CMD_A, 8'h0F);
        bus_read(ADDR_CMD_A);
        bus_write(ADDR_DATA_A, 8'h5A);
        host_pop(1'b1);
    endtask

    // Random traffic, mostly built from well-formed sequences. Register programming
    // writes a pointer and then a value; readback writes a pointer and then reads.
    // Data writes come in bursts of up to 24, which can exceed the FIFO depth, so the
    // FIFOs run full and overflow. Read and pop bursts drain them back to empty. About
    // a tenth of the draws are raw noise items over the whole input space.
    task automatic run_traffic(int quota);
        int         target;
        int         kind;
        int         len;
        logic       ch;
        logic [3:0] cmd_addr;
        logic [3:0] data_addr;
        logic [3:0] p;
        logic [7:0] b;
        target = counted_items + quota;
        while (counted_items < target) begin
            ch = 1'($urandom_range(1));
            cmd_addr = ch ? ADDR_CMD_A : ADDR_CMD_B;
            data_addr = ch ? ADDR_DATA_A : ADDR_DATA_B;
            kind = $urandom_range(99);
            b = 8'($urandom_range(255));
            if (kind < 12) begin
                // Register 14 is picked often, so loopback keeps switching on and off.
                p = ($urandom_range(3) == 0) ? LOOPBACK_REG : 4'($urandom_range(15));
                b[3:0] = p;
                bus_write(cmd_addr, b);
                bus_write(cmd_addr, 8'($urandom_range(255)));
            end else if (kind < 22) begin
                bus_write(cmd_addr, b);
                bus_read(cmd_addr);
            end else if (kind < 28) begin
                bus_read(cmd_addr);
            end else if (kind < 55) begin
                len = $urandom_range(24, 1);
                repeat (len) bus_write(data_addr, 8'($urandom_range(255)));
            end else if (kind < 70) begin
                len = $urandom_range(20, 1);
                repeat (len) bus_read(data_addr);
            end else if (kind < 90) begin
                len = $urandom_range(20, 1);
                repeat (len) host_pop(ch);
            end else begin
                send_item('{op: 2'($urandom_range(3)), reg_addr: 4'($urandom_range(15)),
                            write_data: b, host_channel: ch});
            end
        end
    endtask

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_item = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        counted_items = 0;
        quiet_cycles = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // First phase: both sides run flat out.
        run_directed();
        run_traffic(ITEMS_PER_PHASE);
        // Second phase: the sender is mostly idle.
        send_idle_pct = 81;
        run_traffic(ITEMS_PER_PHASE);
        // Third phase: the receiver stalls most of the time, so backpressure reaches push.
        send_idle_pct = 0;
        recv_stall_pct = 81;
        run_traffic(ITEMS_PER_PHASE);
        // Fourth phase: light idling on both sides.
        send_idle_pct = 11;
        recv_stall_pct = 11;
        run_traffic(ITEMS_PER_PHASE);
        push <= 1'b0;

        // Drain. The watchdog catches a result that never comes. The tail then gives
        // any stray extra result time to show up and be flagged.
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Covered %0d items in four traffic phases; %0d results checked, %0d errors.",
                 counted_items, sb.checked, sb.errors);
        $display("Saw %0d loopback writes, %0d dropped items, %0d bytes handed to the host.",
                 sb.loopbacks, sb.drops, sb.tx_handed);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
